/* sv/cwfb_pkg.sv */
// Shared types, constants and CRC-15 helpers for the configuration frame builder.
package cwfb_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  OPCODE_WRCFG = 8'h01;
    localparam logic [7:0]  ADDR_BCAST   = 8'h00;
    localparam logic [15:0] CRC15_POLY   = 16'h4599;
    localparam logic [15:0] CRC15_SEED   = 16'd16;

    localparam logic [3:0] IDX_ADDR        = 4'd0;
    localparam logic [3:0] IDX_OPCODE      = 4'd1;
    localparam logic [3:0] IDX_HDR_PEC_HI  = 4'd2;
    localparam logic [3:0] IDX_HDR_PEC_LO  = 4'd3;
    localparam logic [3:0] IDX_DATA_FIRST  = 4'd4;
    localparam logic [3:0] IDX_DATA_PEC_HI = 4'd10;
    localparam logic [3:0] IDX_DATA_PEC_LO = 4'd11;
    localparam logic [3:0] IDX_LAST        = 4'd11;

    localparam int SETTINGS_DEPTH = 6;

    typedef enum logic [1:0] {
        CMD_SEND      = 2'd0,
        CMD_DEFAULTS  = 2'd1,
        CMD_DISCHARGE = 2'd2,
        CMD_UNUSED    = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  addr_byte;
        logic [11:0] bitmap;
        logic [7:0]  timeout;
    } t_job;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_SEND = 1'b1
    } t_back_state;

    function automatic logic [15:0] crc15_entry(input logic [7:0] idx);
        logic [15:0] r;
        r = {1'b0, idx, 7'd0};
        for (int b = 0; b < 8; b++) begin
            if (r[14]) begin
                r = {r[14:0], 1'b0} ^ CRC15_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] crc15_update(input logic [15:0] rem, input logic [7:0] d);
        logic [7:0] a;
        a = rem[14:7] ^ d;
        return {rem[7:0], 8'd0} ^ crc15_entry(a);
    endfunction

endpackage

/* sv/cwfb_front.sv */
// Front end: accepts commands, forms the address byte and queues the job.
module cwfb_front (
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_command,
    input  logic              i_to_all,
    input  logic [3:0]        i_chip_address,
    input  logic [11:0]       i_discharge_bitmap,
    input  logic [7:0]        i_timeout_bits,
    input  logic              i_full,
    output logic              o_push,
    output cwfb_pkg::t_job    o_job
);
    import cwfb_pkg::*;

    t_cmd w_cmd;

    assign w_cmd   = t_cmd'(i_command);
    assign o_stall = i_full;
    // drop the unused command code without queuing anything
    assign o_push  = i_valid && !i_full && (w_cmd != CMD_UNUSED);

    always_comb begin
        o_job.cmd     = w_cmd;
        o_job.bitmap  = i_discharge_bitmap;
        o_job.timeout = i_timeout_bits;
        if (i_to_all || (w_cmd == CMD_DEFAULTS)) begin
            o_job.addr_byte = ADDR_BCAST;
        end else begin
            o_job.addr_byte = {1'b1, i_chip_address, 3'd0};
        end
    end

endmodule

/* sv/cwfb_queue.sv */
// Short job queue between the front end and the frame sequencer.
module cwfb_queue #(
    parameter int DEPTH = cwfb_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cwfb_pkg::t_job    i_job,
    output logic              o_full,
    input  logic              i_pop,
    output cwfb_pkg::t_job    o_job,
    output logic              o_empty
);
    import cwfb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job           r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  n_wr;
    logic [PW-1:0]  n_rd;
    logic [CW-1:0]  n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

/* sv/cwfb_back.sv */
// Back end: applies the settings update and emits the twelve frame bytes with PECs.
module cwfb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cwfb_pkg::t_job    i_job,
    input  logic              i_job_valid,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_frame_byte,
    output logic [3:0]        o_byte_index,
    output logic              o_last_byte
);
    import cwfb_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [7:0]  r_settings [SETTINGS_DEPTH];
    logic [7:0]  n_settings [SETTINGS_DEPTH];
    logic [7:0]  r_addr_byte;
    logic [7:0]  n_addr_byte;
    logic [3:0]  r_idx;
    logic [3:0]  n_idx;
    logic [15:0] r_rem;
    logic [15:0] n_rem;

    logic        r_out_valid;
    logic        n_out_valid;
    logic [7:0]  r_out_byte;
    logic [7:0]  n_out_byte;
    logic [3:0]  r_out_index;
    logic [3:0]  n_out_index;
    logic        r_out_last;
    logic        n_out_last;

    logic        w_out_free;
    logic        w_advance;
    logic [2:0]  w_sel;
    logic [7:0]  w_byte;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_advance  = (r_state == BK_SEND) && w_out_free;
    assign w_sel      = 3'(r_idx - IDX_DATA_FIRST);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    n_state = BK_SEND;
                end
            end
            BK_SEND: begin
                if (w_out_free && (r_idx == IDX_LAST)) begin
                    n_state = BK_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        unique case (r_idx)
            IDX_ADDR:        w_byte = r_addr_byte;
            IDX_OPCODE:      w_byte = OPCODE_WRCFG;
            IDX_HDR_PEC_HI,
            IDX_DATA_PEC_HI: w_byte = r_rem[14:7];
            IDX_HDR_PEC_LO,
            IDX_DATA_PEC_LO: w_byte = {r_rem[6:0], 1'b0};
            default:         w_byte = r_settings[w_sel];
        endcase
    end

    always_comb begin
        o_pop       = (r_state == BK_IDLE) && i_job_valid;
        n_settings  = r_settings;
        n_addr_byte = r_addr_byte;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_out_valid = r_out_valid && i_stall;
        n_out_byte  = r_out_byte;
        n_out_index = r_out_index;
        n_out_last  = r_out_last;
        if (o_pop) begin
            n_addr_byte = i_job.addr_byte;
            n_idx       = IDX_ADDR;
            n_rem       = CRC15_SEED;
            unique case (i_job.cmd)
                CMD_DEFAULTS: begin
                    n_settings[0] = 8'hFF;
                    for (int k = 1; k < SETTINGS_DEPTH; k++) begin
                        n_settings[k] = 8'h00;
                    end
                end
                CMD_DISCHARGE: begin
                    n_settings[4] = i_job.bitmap[7:0];
                    n_settings[5] = {4'd0, i_job.bitmap[11:8]} | i_job.timeout;
                end
                default: begin
                end
            endcase
        end
        if (w_advance) begin
            n_out_valid = 1'b1;
            n_out_byte  = w_byte;
            n_out_index = r_idx;
            n_out_last  = (r_idx == IDX_LAST);
            n_idx       = r_idx + 1'b1;
            unique case (r_idx)
                IDX_HDR_PEC_LO:  n_rem = CRC15_SEED;
                IDX_HDR_PEC_HI,
                IDX_DATA_PEC_HI,
                IDX_DATA_PEC_LO: n_rem = r_rem;
                default:         n_rem = crc15_update(r_rem, w_byte);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < SETTINGS_DEPTH; k++) begin
                r_settings[k] <= 8'h00;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_settings  <= n_settings;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr_byte <= n_addr_byte;
        r_idx       <= n_idx;
        r_rem       <= n_rem;
        r_out_byte  <= n_out_byte;
        r_out_index <= n_out_index;
        r_out_last  <= n_out_last;
    end

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_byte_index = r_out_index;
    assign o_last_byte  = r_out_last;

endmodule

/* sv/config_write_frame_builder.sv */
// Top level of the write-configuration frame builder.
// First beat: the job is queued, popped by the sequencer, then its byte registered out.
// Per command: one queue pop, then 12 byte beats, one a cycle while i_stall is low;
// no new job is popped before the last beat; the unused command code emits no beats.
// Reset: synchronous, active low; clears the queue, the sequencer and the six settings bytes.
module config_write_frame_builder #(
    parameter int QUEUE_DEPTH = cwfb_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic        i_to_all,
    input  logic [3:0]  i_chip_address,
    input  logic [11:0] i_discharge_bitmap,
    input  logic [7:0]  i_timeout_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic [3:0]  o_byte_index,
    output logic        o_last_byte
);
    import cwfb_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_job w_push_job;
    t_job w_head_job;

    cwfb_front u_front (
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_command          (i_command),
        .i_to_all           (i_to_all),
        .i_chip_address     (i_chip_address),
        .i_discharge_bitmap (i_discharge_bitmap),
        .i_timeout_bits     (i_timeout_bits),
        .i_full             (w_full),
        .o_push             (w_push),
        .o_job              (w_push_job)
    );

    cwfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_empty)
    );

    cwfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_head_job),
        .i_job_valid  (!w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_byte_index (o_byte_index),
        .o_last_byte  (o_last_byte)
    );

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_byte == (o_byte_index == IDX_LAST)))
        else $error("last byte flag does not match byte index");

    a_beats_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_byte |=>
            o_valid && (o_byte_index == $past(o_byte_index) + 4'd1))
        else $error("frame beats not contiguous");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_empty |-> !w_pop)
        else $error("job popped from empty queue");

endmodule
